@@ rtl/cgep_pkg.sv @@
// cgep_pkg: shared types and constants for the CSR grid edge partitioner.
// Used by cgep_divider and csr_grid_edge_partitioner_unit; no dependencies.
package cgep_pkg;

    localparam int ID_W      = 31;
    localparam int KW        = 5;
    localparam int PART_W    = 4;
    localparam int OFS_W     = 48;
    localparam int MAX_PARTS = 16;
    localparam int DIV_W     = 32;
    localparam int DIV_BITS  = 2;
    localparam int DIV_CYC   = DIV_W / DIV_BITS;
    localparam int CNT_W     = $clog2(DIV_CYC);

    localparam logic [OFS_W-1:0] OFS_MAX = {OFS_W{1'b1}};
    localparam logic [1:0]       DEG_LOW = 2'd2;

    localparam logic MODE_NB  = 1'b0;
    localparam logic MODE_END = 1'b1;
    localparam logic KIND_ADJ = 1'b0;
    localparam logic KIND_OFS = 1'b1;

    typedef struct packed {
        logic            done;
        logic [ID_W-1:0] quot;
        logic [KW-1:0]   rem;
    } div_rsp_t;

endpackage

@@ rtl/csr_grid_edge_partitioner_unit.sv @@
// csr_grid_edge_partitioner_unit: CSR stream to k-by-k grid, with cell offset table.
// Neighbour word: column divide, table read, then table update; a row divide comes first after any cfg write.
// End word: k offset words, each a table read then an output; one word in flight at a time.
// Throughput set by the shared two-bit-per-cycle divider and the single table port.
// Reset: async, active low; offset table reads as zero through per-cell valid bits.
module csr_grid_edge_partitioner_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cgep_pkg::KW-1:0]       num_parts,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic                          mode,
    input  logic [cgep_pkg::ID_W-1:0]     neighbour,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic                          kind,
    output logic [cgep_pkg::PART_W-1:0]   row_part,
    output logic [cgep_pkg::PART_W-1:0]   col_part,
    output logic [cgep_pkg::ID_W-1:0]     local_id,
    output logic [cgep_pkg::OFS_W-1:0]    offset,
    output logic                          last,
    output logic                          low_degree_found,
    output logic [cgep_pkg::ID_W-1:0]     first_low_degree_vertex
);
    import cgep_pkg::*;

    localparam int DEPTH = MAX_PARTS * MAX_PARTS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IDX_W = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
    localparam int K_CAP = (MAX_PARTS > 31) ? 31 : MAX_PARTS;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_ROWDIV = 7'b0000010,
        S_NBDIV  = 7'b0000100,
        S_MEMRD  = 7'b0001000,
        S_MEMUPD = 7'b0010000,
        S_OFSRD  = 7'b0100000,
        S_OFSOUT = 7'b1000000
    } state_t;

    function automatic logic [AW-1:0] cell_addr(input logic [IDX_W-1:0] r,
                                                input logic [KW-1:0] c);
        return AW'(AW'(r) * AW'(MAX_PARTS)) + AW'(c);
    endfunction

    state_t              state_reg, state_next;
    logic [KW-1:0]       np_reg, np_next;
    logic [KW-1:0]       k_reg, k_next;
    logic [KW-1:0]       grid_k;
    logic                row_stale_reg, row_stale_next;
    logic [IDX_W-1:0]    row_reg, row_next;
    logic [ID_W-1:0]     vertex_reg, vertex_next;
    logic [1:0]          deg_reg, deg_next;
    logic                low_seen_reg, low_seen_next;
    logic [ID_W-1:0]     low_vertex_reg, low_vertex_next;
    logic [KW-1:0]       j_reg, j_next;
    logic [KW-1:0]       j_plus;
    logic [KW:0]         row_plus;

    logic                mode_reg;
    logic [ID_W-1:0]     nb_reg;
    logic [KW-1:0]       col_reg, col_next;
    logic [ID_W-1:0]     local_reg, local_next;
    logic [AW-1:0]       addr_reg, addr_next;

    logic                div_start;
    logic [ID_W-1:0]     div_dividend;
    div_rsp_t            div_rsp;

    logic [OFS_W-1:0]    mem [DEPTH];
    logic [OFS_W-1:0]    mem_q_reg;
    logic [DEPTH-1:0]    valid_reg;
    logic                mem_re, mem_we;
    logic [AW-1:0]       rd_addr;
    logic [OFS_W-1:0]    cur_ofs;

    logic                result_valid_reg;
    logic                kind_reg;
    logic [PART_W-1:0]   row_part_reg, col_part_reg;
    logic [ID_W-1:0]     local_id_reg;
    logic [OFS_W-1:0]    offset_reg;
    logic                last_reg;
    logic                low_found_reg;
    logic [ID_W-1:0]     low_out_reg;

    logic                out_free, out_load, out_kind, out_last;
    logic [KW-1:0]       out_col;
    logic [ID_W-1:0]     out_local;
    logic [OFS_W-1:0]    out_offset;

    // divisor is latched on start, so it takes the grid size of the word being accepted
    cgep_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (k_next),
        .rsp      (div_rsp)
    );

    always_comb
    begin
        if (np_reg == '0)
            grid_k = KW'(1);
        else if (np_reg > KW'(K_CAP))
            grid_k = KW'(K_CAP);
        else
            grid_k = np_reg;
    end

    assign out_free = !result_valid_reg || !result_stall;
    assign j_plus   = j_reg + KW'(1);
    assign row_plus = (KW + 1)'(row_reg) + (KW + 1)'(1);
    assign cur_ofs  = valid_reg[addr_reg] ? mem_q_reg : '0;

    always_comb
    begin
        state_next      = state_reg;
        np_next         = np_reg;
        k_next          = k_reg;
        row_stale_next  = row_stale_reg;
        row_next        = row_reg;
        vertex_next     = vertex_reg;
        deg_next        = deg_reg;
        low_seen_next   = low_seen_reg;
        low_vertex_next = low_vertex_reg;
        j_next          = j_reg;
        col_next        = col_reg;
        local_next      = local_reg;
        addr_next       = addr_reg;
        div_start       = 1'b0;
        div_dividend    = nb_reg;
        mem_re          = 1'b0;
        mem_we          = 1'b0;
        rd_addr         = addr_reg;
        out_load        = 1'b0;
        out_kind        = KIND_ADJ;
        out_col         = col_reg;
        out_local       = local_reg;
        out_offset      = '0;
        out_last        = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    k_next = grid_k;
                    j_next = '0;
                    if (row_stale_reg)
                    begin
                        div_start    = 1'b1;
                        div_dividend = vertex_reg;
                        state_next   = S_ROWDIV;
                    end
                    else if (mode == MODE_NB)
                    begin
                        div_start    = 1'b1;
                        div_dividend = neighbour;
                        state_next   = S_NBDIV;
                    end
                    else
                    begin
                        state_next = S_OFSRD;
                    end
                end
            end
            S_ROWDIV:
            begin
                if (div_rsp.done)
                begin
                    row_next       = IDX_W'(div_rsp.rem);
                    row_stale_next = 1'b0;
                    if (mode_reg == MODE_NB)
                    begin
                        div_start  = 1'b1;
                        state_next = S_NBDIV;
                    end
                    else
                    begin
                        state_next = S_OFSRD;
                    end
                end
            end
            S_NBDIV:
            begin
                if (div_rsp.done)
                begin
                    col_next   = div_rsp.rem;
                    local_next = div_rsp.quot;
                    addr_next  = cell_addr(row_reg, div_rsp.rem);
                    state_next = S_MEMRD;
                end
            end
            S_MEMRD:
            begin
                mem_re     = 1'b1;
                state_next = S_MEMUPD;
            end
            S_MEMUPD:
            begin
                if (out_free)
                begin
                    mem_we   = 1'b1;
                    out_load = 1'b1;
                    if (deg_reg < DEG_LOW)
                        deg_next = deg_reg + 2'd1;
                    state_next = S_IDLE;
                end
            end
            S_OFSRD:
            begin
                mem_re    = 1'b1;
                rd_addr   = cell_addr(row_reg, j_reg);
                addr_next = rd_addr;
                if (j_reg == '0 && !low_seen_reg && deg_reg < DEG_LOW)
                begin
                    low_seen_next   = 1'b1;
                    low_vertex_next = vertex_reg;
                end
                state_next = S_OFSOUT;
            end
            S_OFSOUT:
            begin
                out_kind   = KIND_OFS;
                out_col    = j_reg;
                out_local  = '0;
                out_offset = cur_ofs;
                out_last   = (j_plus == k_reg);
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (out_last)
                    begin
                        vertex_next = vertex_reg + ID_W'(1);
                        deg_next    = '0;
                        if (vertex_next == '0 || row_plus == {1'b0, k_reg})
                            row_next = '0;
                        else
                            row_next = row_reg + IDX_W'(1);
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        j_next     = j_plus;
                        state_next = S_OFSRD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_valid)
        begin
            np_next        = num_parts;
            row_stale_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            np_reg           <= KW'(1);
            k_reg            <= KW'(1);
            row_stale_reg    <= 1'b0;
            row_reg          <= '0;
            vertex_reg       <= '0;
            deg_reg          <= '0;
            low_seen_reg     <= 1'b0;
            low_vertex_reg   <= '0;
            j_reg            <= '0;
            valid_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            np_reg         <= np_next;
            k_reg          <= k_next;
            row_stale_reg  <= row_stale_next;
            row_reg        <= row_next;
            vertex_reg     <= vertex_next;
            deg_reg        <= deg_next;
            low_seen_reg   <= low_seen_next;
            low_vertex_reg <= low_vertex_next;
            j_reg          <= j_next;
            if (mem_we)
                valid_reg[addr_reg] <= 1'b1;
            if (out_load)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && item_valid)
        begin
            mode_reg <= mode;
            nb_reg   <= neighbour;
        end
        col_reg   <= col_next;
        local_reg <= local_next;
        addr_reg  <= addr_next;
        if (out_load)
        begin
            kind_reg     <= out_kind;
            row_part_reg <= PART_W'(row_reg);
            col_part_reg <= PART_W'(out_col);
            local_id_reg <= out_local;
            offset_reg   <= out_offset;
            last_reg     <= out_last;
            low_found_reg <= low_seen_reg;
            low_out_reg  <= low_vertex_reg;
        end
    end

    // offset table: one port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[addr_reg] <= (cur_ofs == OFS_MAX) ? cur_ofs : cur_ofs + OFS_W'(1);
        if (mem_re)
            mem_q_reg <= mem[rd_addr];
    end

    assign cfg_ready               = 1'b1;
    assign item_stall              = (state_reg != S_IDLE);
    assign result_valid            = result_valid_reg;
    assign kind                    = kind_reg;
    assign row_part                = row_part_reg;
    assign col_part                = col_part_reg;
    assign local_id                = local_id_reg;
    assign offset                  = offset_reg;
    assign last                    = last_reg;
    assign low_degree_found        = low_found_reg;
    assign first_low_degree_vertex = low_out_reg;

`ifndef ASSERT_OFF
    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && !row_stale_reg) |-> ((KW + 1)'(row_reg) < {1'b0, k_reg}))
        else $error("row index not below grid size");

    a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_ROWDIV || state_reg == S_NBDIV))
        else $error("divider finished outside a divide state");

    a_write_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> valid_reg[$past(addr_reg)])
        else $error("table write did not mark cell valid");

    a_last_closes_vertex: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_last && state_reg == S_OFSOUT) |=>
            (state_reg == S_IDLE && deg_reg == 2'd0))
        else $error("last offset word did not close the vertex");
`endif

endmodule

@@ rtl/cgep_divider.sv @@
// cgep_divider: iterative restoring divider, 31-bit id by 5-bit grid size.
// Two quotient bits per cycle; depends on cgep_pkg.
module cgep_divider (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [cgep_pkg::ID_W-1:0] dividend,
    input  logic [cgep_pkg::KW-1:0]   divisor,
    output cgep_pkg::div_rsp_t        rsp
);
    import cgep_pkg::*;

    logic [DIV_W-1:0] work_reg, work_next;
    logic [KW-1:0]    rem_reg, rem_next;
    logic [KW-1:0]    dsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    always_comb
    begin
        logic [KW:0] t;
        t         = '0;
        work_next = work_reg;
        rem_next  = rem_reg;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            t         = {rem_next, work_next[DIV_W-1]};
            work_next = {work_next[DIV_W-2:0], 1'b0};
            if (t >= {1'b0, dsr_reg})
            begin
                rem_next     = KW'(t - {1'b0, dsr_reg});
                work_next[0] = 1'b1;
            end
            else
            begin
                rem_next = t[KW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_CYC - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= {1'b0, dividend};
            rem_reg  <= '0;
            dsr_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = work_reg[ID_W-1:0];
    assign rsp.rem  = rem_reg;

endmodule
